// ===== src/flat_json_object_parser_core_macros.svh =====
// assertion helpers used by the parser back end
`ifndef FLAT_JSON_OBJECT_PARSER_CORE_MACROS_SVH
`define FLAT_JSON_OBJECT_PARSER_CORE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define FJP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FJP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/fjp_pkg.sv =====
package fjp_pkg;

  // default queue depths
  localparam int FJP_IN_DEPTH  = 4;
  localparam int FJP_OUT_DEPTH = 4;

  // one input item
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic [2:0]         event_kind;
    logic [7:0]         char_out;
    logic signed [63:0] number_out;
    logic [2:0]         error_code;
    logic               last_of_run;
  } out_item_t;

  // byte class found by the front end
  typedef enum logic [3:0] {
    TK_WS,
    TK_ZERO,
    TK_DIGIT,
    TK_LBRACE,
    TK_RBRACE,
    TK_QUOTE,
    TK_COLON,
    TK_COMMA,
    TK_MINUS,
    TK_OTHER
  } tok_t;

  // classified item handed from front to back
  typedef struct packed {
    in_item_t item;
    tok_t     tok;
  } tok_item_t;

  // all results caused by one item (one or two)
  typedef struct packed {
    logic      two;
    out_item_t res0;
    out_item_t res1;
  } pair_t;

  // parser phases
  typedef enum logic [3:0] {
    PH_START = 4'd0,
    PH_OPEN  = 4'd1,
    PH_KEY   = 4'd2,
    PH_COLON = 4'd3,
    PH_VALUE = 4'd4,
    PH_STR   = 4'd5,
    PH_NUM   = 4'd6,
    PH_AFTER = 4'd7,
    PH_DRAIN = 4'd8
  } phase_t;

  // event kinds
  localparam logic [2:0] EV_KEY_BYTE = 3'd0;
  localparam logic [2:0] EV_KEY_END  = 3'd1;
  localparam logic [2:0] EV_STR_BYTE = 3'd2;
  localparam logic [2:0] EV_STR_END  = 3'd3;
  localparam logic [2:0] EV_NUMBER   = 3'd4;
  localparam logic [2:0] EV_DONE     = 3'd5;
  localparam logic [2:0] EV_ERROR    = 3'd6;

  // error codes
  localparam logic [2:0] ERR_NO_OPEN    = 3'd0;
  localparam logic [2:0] ERR_KEY_QUOTE  = 3'd1;
  localparam logic [2:0] ERR_OPEN_KEY   = 3'd2;
  localparam logic [2:0] ERR_NO_COLON   = 3'd3;
  localparam logic [2:0] ERR_OPEN_STR   = 3'd4;
  localparam logic [2:0] ERR_BAD_VALUE  = 3'd5;
  localparam logic [2:0] ERR_NO_SEP     = 3'd6;
  localparam logic [2:0] ERR_NO_CLOSE   = 3'd7;

  // saturation limits
  localparam logic signed [63:0] NUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] NUM_MIN = 64'sh8000_0000_0000_0000;

endpackage

// ===== src/fjp_queue.sv =====
module fjp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== src/fjp_front.sv =====
module fjp_front
  import fjp_pkg::*;
#(
  parameter int DEPTH = FJP_IN_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  in_item_t  in_item,
  output logic      full,
  input  logic      q_pop,
  output tok_item_t q_item,
  output logic      q_empty
);

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;

  tok_item_t                    wr_item;
  logic [$bits(tok_item_t)-1:0] q_raw;

  // byte classifier
  function automatic tok_t classify(input logic [7:0] b);
    tok_t t;
    if (b == 8'h00) begin
      t = TK_ZERO;
    end else if (b inside {8'h20, [8'h09:8'h0D]}) begin
      t = TK_WS;
    end else if (b inside {[8'h30:8'h39]}) begin
      t = TK_DIGIT;
    end else begin
      case (b)
        CH_LBRACE: t = TK_LBRACE;
        CH_RBRACE: t = TK_RBRACE;
        CH_QUOTE:  t = TK_QUOTE;
        CH_COLON:  t = TK_COLON;
        CH_COMMA:  t = TK_COMMA;
        CH_MINUS:  t = TK_MINUS;
        default:   t = TK_OTHER;
      endcase
    end
    return t;
  endfunction

  assign wr_item.item = in_item;
  assign wr_item.tok  = classify(in_item.text_byte);

  // decoupling queue toward the parser
  fjp_queue #(
    .WIDTH ($bits(tok_item_t)),
    .DEPTH (DEPTH)
  ) u_in_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (wr_item),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_raw),
    .empty (q_empty)
  );

  assign q_item = tok_item_t'(q_raw);

endmodule

// ===== src/fjp_back.sv =====
module fjp_back
  import fjp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  tok_item_t q_item,
  output logic      q_pop,
  input  logic      p_full,
  output logic      p_push,
  output pair_t     p_data
);

  `include "flat_json_object_parser_core_macros.svh"

  localparam logic [67:0] ACC_HI = 68'h0_7FFF_FFFF_FFFF_FFFF;
  localparam logic [67:0] ACC_LO = 68'hF_8000_0000_0000_0000;

  phase_t             phase_r, phase_nxt, ph1;
  logic signed [63:0] acc_r, acc_nxt, acc1;
  logic               neg_r, neg_nxt, neg1;
  logic               seen_r, seen_nxt, seen1;
  logic               ovf_r, ovf_nxt, ovf1;

  logic        take;
  logic [7:0]  b;
  logic [3:0]  dval;
  tok_t        tok;
  logic        last;
  logic [67:0] ext, dterm, sum;
  logic        add_ovf;
  logic        has_num1, has_ev1, do_after, do2, has_num2;
  out_item_t   ev1, ev2, num1_ev, num2_ev, slot0, slot1;
  logic [1:0]  cnt;

  function automatic out_item_t mk_ev(input logic [2:0] kind, input logic [7:0] ch,
                                      input logic signed [63:0] num,
                                      input logic [2:0] err);
    out_item_t e;
    e.event_kind  = kind;
    e.char_out    = ch;
    e.number_out  = num;
    e.error_code  = err;
    e.last_of_run = 1'b0;
    return e;
  endfunction

  function automatic logic signed [63:0] num_val(input logic signed [63:0] acc,
                                                 input logic neg, input logic ovf);
    logic signed [63:0] v;
    if (ovf) begin
      v = neg ? NUM_MIN : NUM_MAX;
    end else begin
      v = acc;
    end
    return v;
  endfunction

  assign take  = !q_empty && !p_full;
  assign q_pop = take;
  assign b     = q_item.item.text_byte;
  assign last  = q_item.item.end_of_text;
  assign tok   = q_item.tok;
  assign dval  = b[3:0];

  // signed accumulate: acc * 10 plus or minus the digit
  always_comb begin
    ext     = {{4{acc_r[63]}}, acc_r};
    dterm   = neg_r ? (68'd0 - {64'd0, dval}) : {64'd0, dval};
    sum     = (ext << 3) + (ext << 1) + dterm;
    add_ovf = neg_r ? ($signed(sum) < $signed(ACC_LO)) : ($signed(sum) > $signed(ACC_HI));
  end

  // first pass: the byte itself
  always_comb begin
    ph1      = phase_r;
    acc1     = acc_r;
    neg1     = neg_r;
    seen1    = seen_r;
    ovf1     = ovf_r;
    has_num1 = 1'b0;
    has_ev1  = 1'b0;
    do_after = 1'b0;
    ev1      = mk_ev(EV_ERROR, 8'd0, 64'sd0, ERR_NO_OPEN);
    case (phase_r)
      PH_START: begin
        if (tok == TK_LBRACE) begin
          ph1 = PH_OPEN;
        end else if (tok != TK_WS) begin
          has_ev1 = 1'b1;
          ph1     = PH_DRAIN;
        end
      end
      PH_OPEN: begin
        if (tok == TK_RBRACE) begin
          has_ev1 = 1'b1;
          ev1     = mk_ev(EV_DONE, 8'd0, 64'sd0, 3'd0);
          ph1     = PH_DRAIN;
        end else if (tok == TK_QUOTE) begin
          ph1 = PH_KEY;
        end else if (tok != TK_WS) begin
          has_ev1 = 1'b1;
          ev1     = mk_ev(EV_ERROR, 8'd0, 64'sd0,
                          (tok == TK_ZERO) ? ERR_NO_CLOSE : ERR_KEY_QUOTE);
          ph1     = PH_DRAIN;
        end
      end
      PH_KEY: begin
        has_ev1 = 1'b1;
        if (tok == TK_QUOTE) begin
          ev1 = mk_ev(EV_KEY_END, 8'd0, 64'sd0, 3'd0);
          ph1 = PH_COLON;
        end else if (tok == TK_ZERO) begin
          ev1 = mk_ev(EV_ERROR, 8'd0, 64'sd0, ERR_OPEN_KEY);
          ph1 = PH_DRAIN;
        end else begin
          ev1 = mk_ev(EV_KEY_BYTE, b, 64'sd0, 3'd0);
        end
      end
      PH_COLON: begin
        if (tok == TK_COLON) begin
          ph1 = PH_VALUE;
        end else if (tok != TK_WS) begin
          has_ev1 = 1'b1;
          ev1     = mk_ev(EV_ERROR, 8'd0, 64'sd0, ERR_NO_COLON);
          ph1     = PH_DRAIN;
        end
      end
      PH_VALUE: begin
        if (tok == TK_QUOTE) begin
          ph1 = PH_STR;
        end else if (tok == TK_MINUS) begin
          acc1  = 64'sd0;
          neg1  = 1'b1;
          seen1 = 1'b0;
          ovf1  = 1'b0;
          ph1   = PH_NUM;
        end else if (tok == TK_DIGIT) begin
          acc1  = {60'd0, dval};
          neg1  = 1'b0;
          seen1 = 1'b1;
          ovf1  = 1'b0;
          ph1   = PH_NUM;
        end else if (tok != TK_WS) begin
          has_ev1 = 1'b1;
          ev1     = mk_ev(EV_ERROR, 8'd0, 64'sd0, ERR_BAD_VALUE);
          ph1     = PH_DRAIN;
        end
      end
      PH_STR: begin
        has_ev1 = 1'b1;
        if (tok == TK_QUOTE) begin
          ev1 = mk_ev(EV_STR_END, 8'd0, 64'sd0, 3'd0);
          ph1 = PH_AFTER;
        end else if (tok == TK_ZERO) begin
          ev1 = mk_ev(EV_ERROR, 8'd0, 64'sd0, ERR_OPEN_STR);
          ph1 = PH_DRAIN;
        end else begin
          ev1 = mk_ev(EV_STR_BYTE, b, 64'sd0, 3'd0);
        end
      end
      PH_NUM: begin
        if (tok == TK_DIGIT) begin
          seen1 = 1'b1;
          if (!ovf_r) begin
            if (add_ovf) begin
              ovf1 = 1'b1;
            end else begin
              acc1 = sum[63:0];
            end
          end
        end else if (!seen_r) begin
          has_ev1 = 1'b1;
          ev1     = mk_ev(EV_ERROR, 8'd0, 64'sd0, ERR_NO_SEP);
          ph1     = PH_DRAIN;
        end else begin
          has_num1 = 1'b1;
          do_after = 1'b1;
        end
      end
      PH_AFTER: begin
        do_after = 1'b1;
      end
      default: begin
      end
    endcase
    // byte that follows a value
    if (do_after) begin
      case (tok)
        TK_WS: begin
          ph1 = PH_AFTER;
        end
        TK_COMMA: begin
          ph1 = PH_OPEN;
        end
        TK_RBRACE: begin
          has_ev1 = 1'b1;
          ev1     = mk_ev(EV_DONE, 8'd0, 64'sd0, 3'd0);
          ph1     = PH_DRAIN;
        end
        default: begin
          has_ev1 = 1'b1;
          ev1     = mk_ev(EV_ERROR, 8'd0, 64'sd0, ERR_NO_SEP);
          ph1     = PH_DRAIN;
        end
      endcase
    end
  end

  // second pass: implied terminator after a flagged last byte
  always_comb begin
    do2      = last && (tok != TK_ZERO) && (ph1 < PH_DRAIN);
    has_num2 = 1'b0;
    ev2      = mk_ev(EV_ERROR, 8'd0, 64'sd0, ERR_NO_SEP);
    case (ph1)
      PH_START: ev2 = mk_ev(EV_ERROR, 8'd0, 64'sd0, ERR_NO_OPEN);
      PH_OPEN:  ev2 = mk_ev(EV_ERROR, 8'd0, 64'sd0, ERR_NO_CLOSE);
      PH_KEY:   ev2 = mk_ev(EV_ERROR, 8'd0, 64'sd0, ERR_OPEN_KEY);
      PH_COLON: ev2 = mk_ev(EV_ERROR, 8'd0, 64'sd0, ERR_NO_COLON);
      PH_VALUE: ev2 = mk_ev(EV_ERROR, 8'd0, 64'sd0, ERR_BAD_VALUE);
      PH_STR:   ev2 = mk_ev(EV_ERROR, 8'd0, 64'sd0, ERR_OPEN_STR);
      PH_NUM:   has_num2 = do2 && seen1;
      default: begin
      end
    endcase
    num1_ev = mk_ev(EV_NUMBER, 8'd0, num_val(acc_r, neg_r, ovf_r), 3'd0);
    num2_ev = mk_ev(EV_NUMBER, 8'd0, num_val(acc1, neg1, ovf1), 3'd0);
  end

  // keep the first two results in order
  always_comb begin
    cnt   = 2'd0;
    slot0 = num1_ev;
    slot1 = num1_ev;
    if (has_num1) begin
      slot0 = num1_ev;
      cnt   = 2'd1;
    end
    if (has_ev1) begin
      if (cnt == 2'd0) slot0 = ev1;
      else             slot1 = ev1;
      cnt = cnt + 2'd1;
    end
    if (has_num2 && cnt < 2'd2) begin
      if (cnt == 2'd0) slot0 = num2_ev;
      else             slot1 = num2_ev;
      cnt = cnt + 2'd1;
    end
    if (do2 && cnt < 2'd2) begin
      if (cnt == 2'd0) slot0 = ev2;
      else             slot1 = ev2;
      cnt = cnt + 2'd1;
    end
    p_data.two  = (cnt == 2'd2);
    p_data.res0 = slot0;
    p_data.res1 = slot1;
    p_data.res0.last_of_run = (cnt == 2'd1);
    p_data.res1.last_of_run = 1'b1;
  end

  assign p_push = take && (cnt != 2'd0);

  // state after this item
  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    seen_nxt  = seen_r;
    ovf_nxt   = ovf_r;
    if (take) begin
      if (last) begin
        phase_nxt = PH_START;
        acc_nxt   = 64'sd0;
        neg_nxt   = 1'b0;
        seen_nxt  = 1'b0;
        ovf_nxt   = 1'b0;
      end else begin
        phase_nxt = ph1;
        acc_nxt   = acc1;
        neg_nxt   = neg1;
        seen_nxt  = seen1;
        ovf_nxt   = ovf1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      acc_r   <= 64'sd0;
      neg_r   <= 1'b0;
      seen_r  <= 1'b0;
      ovf_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      seen_r  <= seen_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // checks
  `FJP_ASSERT_NOW(a_run_mark, p_push,
    (p_data.two ? (p_data.res1.last_of_run && !p_data.res0.last_of_run)
                : p_data.res0.last_of_run),
    "last_of_run not on the final result of an item")
  `FJP_ASSERT_NOW(a_drain_quiet, take && (phase_r == PH_DRAIN), !p_push,
    "result produced while dropping text")
  `FJP_ASSERT_NEXT(a_eot_restart, take && last,
    (phase_r == PH_START) && !seen_r && !ovf_r && !neg_r,
    "parser not restarted after last byte")
  `FJP_ASSERT_NEXT(a_stop_drain,
    p_push && !last && ((p_data.two ? p_data.res1.event_kind : p_data.res0.event_kind)
                        == EV_ERROR),
    phase_r == PH_DRAIN,
    "parser kept going after an error")

endmodule

// ===== src/flat_json_object_parser_core.sv =====
// Flat JSON object parser, one text byte in per cycle unless the queues hold it back.
// Input side is a queue: drive in_item and push; the byte is taken at a
// clock edge where push is high and full is low. end_of_text marks the last
// byte of an object; the next byte starts a new object.
// Result side is a queue too: while empty is low, out_item holds the oldest
// event (key or string bytes, end markers, numbers, done or error); raise
// pop to take it. last_of_run flags the final event caused by one byte.
// An accepted byte passes through the input queue, then the parser step into
// the result queue, before its events can be taken.
// Throughput: 1 byte per cycle while the result queue has room, set by the
// parser step with its 64-bit multiply-by-ten accumulate. A byte that
// causes two events needs two pops; an opening brace not flagged last causes none.
// When pop is held low, the result queue fills, the parser stops, then the
// input queue fills and full rises; nothing is lost.
// Reset (rst_n low, synchronous) empties both queues and returns the
// parser to waiting for an opening brace with cleared number state.
module flat_json_object_parser_core
  import fjp_pkg::*;
#(
  parameter int IN_DEPTH  = FJP_IN_DEPTH,
  parameter int OUT_DEPTH = FJP_OUT_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  in_item_t  in_item,
  output logic      full,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  tok_item_t                q_item;
  logic                     q_pop, q_empty;
  logic                     p_full, p_push;
  pair_t                    p_data, pq_data;
  logic [$bits(pair_t)-1:0] pq_raw;
  logic                     pq_pop;
  logic                     sel_r, sel_nxt;

  // front: accept and classify
  fjp_front #(
    .DEPTH (IN_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_item (in_item),
    .full    (full),
    .q_pop   (q_pop),
    .q_item  (q_item),
    .q_empty (q_empty)
  );

  // back: parse one byte per cycle while the result queue has room
  fjp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .p_full  (p_full),
    .p_push  (p_push),
    .p_data  (p_data)
  );

  // result queue, one entry per byte's results
  fjp_queue #(
    .WIDTH ($bits(pair_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (p_push),
    .wdata (p_data),
    .full  (p_full),
    .pop   (pq_pop),
    .rdata (pq_raw),
    .empty (empty)
  );

  assign pq_data  = pair_t'(pq_raw);
  assign out_item = sel_r ? pq_data.res1 : pq_data.res0;
  assign pq_pop   = pop && !empty && (sel_r || !pq_data.two);

  // step through the one or two results of the head entry
  always_comb begin
    sel_nxt = sel_r;
    if (pop && !empty) begin
      sel_nxt = !sel_r && pq_data.two;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import fjp_pkg::*;

  // text bytes the parser cares about
  localparam logic [7:0] NUL       = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DIGIT0 = 8'h30;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] WS_SET [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

  localparam int RANDOM_ITEMS = 1300;
  localparam int CYCLE_LIMIT  = 800000;

  // events that can be read straight off the text
  localparam out_item_t NO_EVENT      = '0;
  localparam out_item_t WANT_NO_OPEN  = '{EV_ERROR, 8'h00, 64'sd0, ERR_NO_OPEN, 1'b1};
  localparam out_item_t WANT_KEY_FF   = '{EV_KEY_BYTE, 8'hFF, 64'sd0, 3'd0, 1'b1};
  localparam out_item_t WANT_KEY_END  = '{EV_KEY_END, 8'h00, 64'sd0, 3'd0, 1'b1};
  localparam out_item_t WANT_STR_END  = '{EV_STR_END, 8'h00, 64'sd0, 3'd0, 1'b1};
  localparam out_item_t WANT_NO_SEP   = '{EV_ERROR, 8'h00, 64'sd0, ERR_NO_SEP, 1'b1};
  localparam out_item_t WANT_NO_CLOSE = '{EV_ERROR, 8'h00, 64'sd0, ERR_NO_CLOSE, 1'b1};
  localparam out_item_t WANT_DONE     = '{EV_DONE, 8'h00, 64'sd0, 3'd0, 1'b1};

  // directed text: byte, end flag, typed-in event or predictor
  typedef struct packed {
    logic [7:0] b;
    logic       eot;
    logic       typed;
    out_item_t  want;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [30] = '{
    '{8'h78,     1'b0, 1'b1, WANT_NO_OPEN},   // junk before the brace
    '{8'hFF,     1'b1, 1'b0, NO_EVENT},       // dropped, closes the text
    '{CH_SPACE,  1'b0, 1'b0, NO_EVENT},
    '{CH_LBRACE, 1'b0, 1'b0, NO_EVENT},
    '{CH_QUOTE,  1'b0, 1'b0, NO_EVENT},
    '{8'hFF,     1'b0, 1'b1, WANT_KEY_FF},
    '{CH_QUOTE,  1'b0, 1'b1, WANT_KEY_END},
    '{CH_COLON,  1'b0, 1'b0, NO_EVENT},
    '{CH_MINUS,  1'b0, 1'b0, NO_EVENT},
    '{8'h37,     1'b0, 1'b0, NO_EVENT},
    '{CH_COMMA,  1'b0, 1'b0, NO_EVENT},       // number ended by the comma
    '{CH_QUOTE,  1'b0, 1'b0, NO_EVENT},
    '{CH_QUOTE,  1'b0, 1'b0, NO_EVENT},       // empty key
    '{CH_COLON,  1'b0, 1'b0, NO_EVENT},
    '{CH_QUOTE,  1'b0, 1'b0, NO_EVENT},
    '{8'h80,     1'b0, 1'b0, NO_EVENT},
    '{CH_QUOTE,  1'b0, 1'b1, WANT_STR_END},
    '{8'h35,     1'b1, 1'b0, NO_EVENT},       // digit right after a value
    '{CH_LBRACE, 1'b0, 1'b0, NO_EVENT},
    '{CH_QUOTE,  1'b0, 1'b0, NO_EVENT},
    '{CH_QUOTE,  1'b0, 1'b0, NO_EVENT},
    '{CH_COLON,  1'b0, 1'b0, NO_EVENT},
    '{CH_MINUS,  1'b0, 1'b0, NO_EVENT},
    '{8'h61,     1'b0, 1'b1, WANT_NO_SEP},    // lone minus
    '{NUL,       1'b1, 1'b0, NO_EVENT},
    '{CH_LBRACE, 1'b0, 1'b0, NO_EVENT},
    '{NUL,       1'b0, 1'b1, WANT_NO_CLOSE},  // zero byte mid-text
    '{CH_RBRACE, 1'b1, 1'b0, NO_EVENT},       // dropped after the error
    '{CH_LBRACE, 1'b0, 1'b0, NO_EVENT},
    '{CH_RBRACE, 1'b1, 1'b1, WANT_DONE}       // empty object
  };

  logic      clk;
  logic      rst_n   = 1'b0;
  logic      push    = 1'b0;
  in_item_t  in_item = '0;
  logic      pop     = 1'b0;
  logic      full;
  logic      empty;
  out_item_t out_item;

  // parser mirror
  phase_t      prs_phase = PH_START;
  logic [63:0] mag_acc   = '0;
  logic        neg_num   = 1'b0;
  logic        got_digit = 1'b0;
  logic        sat_hit   = 1'b0;
  out_item_t   step_events [2];
  int          step_count;

  out_item_t   parser_events [$];
  logic [7:0]  obj_text [$];
  int          bad_events  = 0;
  int          sent_items  = 0;
  int          cycle_count = 0;
  bit          push_calm   = 1'b0;
  bit          pop_calm    = 1'b0;

  flat_json_object_parser_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_item  (in_item),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // byte classes
  function automatic bit ws_byte(logic [7:0] b);
    return b == CH_SPACE || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic bit digit_byte(logic [7:0] b);
    return b >= CH_DIGIT0 && b <= 8'h39;
  endfunction

  // record one event of the current byte, two at most
  function automatic void note_event(logic [2:0] kind, logic [7:0] ch, logic [63:0] num,
                                     logic [2:0] code);
    if (step_count < 2) begin
      step_events[step_count] = '{event_kind: kind, char_out: ch, number_out: num,
                                  error_code: code, last_of_run: 1'b0};
      step_count++;
    end
  endfunction

  function automatic void raise_error(logic [2:0] code);
    note_event(EV_ERROR, NUL, '0, code);
    prs_phase = PH_DRAIN;
  endfunction

  function automatic void clear_num();
    mag_acc   = '0;
    neg_num   = 1'b0;
    got_digit = 1'b0;
    sat_hit   = 1'b0;
  endfunction

  // accumulate one decimal digit, saturating at the signed limits
  function automatic void take_digit(logic [7:0] b);
    logic [63:0] d;
    logic [63:0] lim;
    d = {56'd0, b} - 64'd48;
    lim = 64'h7FFF_FFFF_FFFF_FFFF + {63'd0, neg_num};
    got_digit = 1'b1;
    if (!sat_hit) begin
      if (mag_acc > (lim - d) / 64'd10) sat_hit = 1'b1;
      else mag_acc = mag_acc * 64'd10 + d;
    end
  endfunction

  function automatic logic [63:0] num_value();
    if (sat_hit) return neg_num ? NUM_MIN : NUM_MAX;
    return neg_num ? 64'd0 - mag_acc : mag_acc;
  endfunction

  // byte following a complete value
  function automatic void close_value(logic [7:0] b);
    if (b != NUL && ws_byte(b)) return;
    if (b == CH_COMMA) begin
      prs_phase = PH_OPEN;
    end else if (b == CH_RBRACE) begin
      note_event(EV_DONE, NUL, '0, 3'd0);
      prs_phase = PH_DRAIN;
    end else begin
      raise_error(ERR_NO_SEP);
    end
  endfunction

  function automatic void parse_char(logic [7:0] b);
    case (prs_phase)
      PH_START: begin
        if (!ws_byte(b)) begin
          if (b == CH_LBRACE) prs_phase = PH_OPEN;
          else raise_error(ERR_NO_OPEN);
        end
      end
      PH_OPEN: begin
        if (!ws_byte(b)) begin
          if (b == CH_RBRACE) begin
            note_event(EV_DONE, NUL, '0, 3'd0);
            prs_phase = PH_DRAIN;
          end else if (b == CH_QUOTE) begin
            prs_phase = PH_KEY;
          end else if (b == NUL) begin
            raise_error(ERR_NO_CLOSE);
          end else begin
            raise_error(ERR_KEY_QUOTE);
          end
        end
      end
      PH_KEY: begin
        if (b == CH_QUOTE) begin
          note_event(EV_KEY_END, NUL, '0, 3'd0);
          prs_phase = PH_COLON;
        end else if (b == NUL) begin
          raise_error(ERR_OPEN_KEY);
        end else begin
          note_event(EV_KEY_BYTE, b, '0, 3'd0);
        end
      end
      PH_COLON: begin
        if (!ws_byte(b)) begin
          if (b == CH_COLON) prs_phase = PH_VALUE;
          else raise_error(ERR_NO_COLON);
        end
      end
      PH_VALUE: begin
        if (!ws_byte(b)) begin
          if (b == CH_QUOTE) begin
            prs_phase = PH_STR;
          end else if (b == CH_MINUS) begin
            clear_num();
            neg_num = 1'b1;
            prs_phase = PH_NUM;
          end else if (digit_byte(b)) begin
            clear_num();
            take_digit(b);
            prs_phase = PH_NUM;
          end else begin
            raise_error(ERR_BAD_VALUE);
          end
        end
      end
      PH_STR: begin
        if (b == CH_QUOTE) begin
          note_event(EV_STR_END, NUL, '0, 3'd0);
          prs_phase = PH_AFTER;
        end else if (b == NUL) begin
          raise_error(ERR_OPEN_STR);
        end else begin
          note_event(EV_STR_BYTE, b, '0, 3'd0);
        end
      end
      PH_NUM: begin
        if (digit_byte(b)) begin
          take_digit(b);
        end else if (!got_digit) begin
          raise_error(ERR_NO_SEP);
        end else begin
          // the terminating byte is also the byte after the value
          note_event(EV_NUMBER, NUL, num_value(), 3'd0);
          prs_phase = PH_AFTER;
          close_value(b);
        end
      end
      PH_AFTER: begin
        close_value(b);
      end
      default: ;
    endcase
  endfunction

  // events caused by one accepted input item
  function automatic void parse_step(in_item_t it);
    step_count = 0;
    if (prs_phase != PH_DRAIN) begin
      parse_char(it.text_byte);
      // unfinished object at the flagged byte sees a terminator too
      if (prs_phase != PH_DRAIN && it.text_byte != NUL && it.end_of_text) parse_char(NUL);
    end
    if (it.end_of_text) begin
      prs_phase = PH_START;
      clear_num();
    end
    if (step_count > 0) step_events[step_count - 1].last_of_run = 1'b1;
  endfunction

  // object text builders
  function automatic void put(logic [7:0] b);
    obj_text.push_back(b);
  endfunction

  function automatic void put_ws();
    int n;
    n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    repeat (n) put(WS_SET[$urandom_range(0, 5)]);
  endfunction

  function automatic void put_quoted();
    int n;
    logic [7:0] c;
    n = $urandom_range(0, 4);
    put(CH_QUOTE);
    repeat (n) begin
      c = $urandom_range(1, 255);
      if (c == CH_QUOTE) c = 8'h41;
      put(c);
    end
    put(CH_QUOTE);
  endfunction

  function automatic void put_number();
    string lim;
    int n;
    bit neg;
    neg = ($urandom_range(0, 2) == 0);
    if (neg) put(CH_MINUS);
    if ($urandom_range(0, 3) == 0) begin
      // digits around the 64-bit limit, sometimes one past it
      lim = neg ? "9223372036854775808" : "9223372036854775807";
      for (int i = 0; i < 18; i++) put(lim[i]);
      put(CH_DIGIT0 + 8'($urandom_range(0, 9)));
      n = $urandom_range(0, 1);
    end else begin
      n = $urandom_range(1, 4);
    end
    repeat (n) put(CH_DIGIT0 + 8'($urandom_range(0, 9)));
  endfunction

  // one object: mostly well formed, some broken, some noise;
  // returns the byte count without trailing filler
  function automatic int build_object();
    int kind;
    int pairs;
    int cut;
    int body;
    obj_text.delete();
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 6)) put(8'($urandom_range(0, 255)));
      return obj_text.size();
    end
    put_ws();
    put(CH_LBRACE);
    put_ws();
    pairs = $urandom_range(0, 3);
    for (int p = 0; p < pairs; p++) begin
      put_quoted();
      put_ws();
      put(CH_COLON);
      put_ws();
      if ($urandom_range(0, 1) == 1) put_quoted();
      else put_number();
      put_ws();
      if (p < pairs - 1 || $urandom_range(0, 3) == 0) begin
        put(CH_COMMA);
        put_ws();
      end
    end
    put(CH_RBRACE);
    if (kind <= 2) begin
      // corrupt one byte or cut the text short
      cut = $urandom_range(0, obj_text.size() - 1);
      if ($urandom_range(0, 1) == 1) obj_text[cut] = 8'($urandom_range(0, 255));
      else obj_text = obj_text[0:cut];
    end
    body = obj_text.size();
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) put(8'($urandom_range(0, 255)));
    return body;
  endfunction

  // push one item and record the events it should cause
  task automatic send_byte(input in_item_t it, input bit typed, input out_item_t want);
    int gap;
    if (sent_items % 40 == 0) push_calm = ($urandom_range(0, 3) == 0);
    gap = push_calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    parse_step(it);
    if (typed) begin
      parser_events.push_back(want);
    end else begin
      for (int i = 0; i < step_count; i++) parser_events.push_back(step_events[i]);
    end
    sent_items++;
  endtask

  // stimulus and verdict
  initial begin : stimulus
    in_item_t it;
    int body_bytes;
    int random_bytes;
    random_bytes = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    foreach (DIR_ROWS[r]) begin
      it.text_byte   = DIR_ROWS[r].b;
      it.end_of_text = DIR_ROWS[r].eot;
      send_byte(it, DIR_ROWS[r].typed, DIR_ROWS[r].want);
    end
    while (random_bytes < RANDOM_ITEMS) begin
      body_bytes = build_object();
      random_bytes += body_bytes;
      for (int i = 0; i < obj_text.size(); i++) begin
        it.text_byte   = obj_text[i];
        it.end_of_text = (i == obj_text.size() - 1);
        send_byte(it, 1'b0, NO_EVENT);
      end
    end
    push <= 1'b0;
    while (parser_events.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (bad_events == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // result side: random pop stalls
  initial begin : consumer
    int gap;
    int taken;
    taken = 0;
    repeat (3) @(posedge clk);
    forever begin
      if (taken % 40 == 0) pop_calm = ($urandom_range(0, 3) == 0);
      gap = pop_calm ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      taken++;
    end
  end

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t %s: expected %0h, got %0h", $time, name, want, got);
      bad_events++;
    end
  endfunction

  // compare each popped item with the oldest predicted event
  always @(posedge clk) begin : event_check
    out_item_t want;
    if (rst_n && pop && !empty) begin
      if (parser_events.size() == 0) begin
        $display("%0t unexpected event: expected none, got %0h", $time, out_item);
        bad_events++;
      end else begin
        want = parser_events.pop_front();
        check_field("event_kind", want.event_kind, out_item.event_kind);
        check_field("char_out", want.char_out, out_item.char_out);
        check_field("number_out", want.number_out, out_item.number_out);
        check_field("error_code", want.error_code, out_item.error_code);
        check_field("last_of_run", want.last_of_run, out_item.last_of_run);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
+incdir+src
src/fjp_pkg.sv
src/fjp_queue.sv
src/fjp_front.sv
src/fjp_back.sv
src/flat_json_object_parser_core.sv
tb/testbench.sv
